@@ sv/ready_queue_scheduler_assert.svh @@
// Assertion macros for the ready queue scheduler.
`ifndef READY_QUEUE_SCHEDULER_ASSERT_SVH
`define READY_QUEUE_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqs assertion failed");

`endif

@@ sv/rqs_pkg.sv @@
// Types, codes and helper functions shared by the ready queue scheduler files.
package rqs_pkg;

   localparam int ID_W      = 16;
   localparam int PRIO_W    = 8;
   localparam int MS_W      = 16;
   localparam int STATUS_W  = 2;
   localparam int OUTCOME_W = 2;
   localparam int OCC_W     = 5;
   localparam int POLICY_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_ENQUEUE  = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

   localparam logic [OUTCOME_W-1:0] OC_REQUEUED = 2'd0;
   localparam logic [OUTCOME_W-1:0] OC_IO       = 2'd1;
   localparam logic [OUTCOME_W-1:0] OC_DONE     = 2'd2;

   localparam logic [POLICY_W-1:0] POL_LOWEST_ID = 2'd0;
   localparam logic [POLICY_W-1:0] POL_SHORTEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_PRIORITY  = 2'd2;
   localparam logic [POLICY_W-1:0] POL_ROUND     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 1'd1;

   localparam logic [MS_W-1:0] QUANTUM_RESET = 16'd10;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [MS_W-1:0]   remaining;
      logic              final_burst;
   } entry_type;

   // True when the candidate beats the current best; ties keep the older entry.
   function automatic logic is_better(entry_type cand, entry_type best,
                                      logic [POLICY_W-1:0] policy);
      logic result;
      case (policy)
         POL_LOWEST_ID: result = cand.id < best.id;
         POL_SHORTEST:  result = cand.remaining < best.remaining;
         POL_PRIORITY:  result = cand.prio > best.prio;
         default:       result = 1'b0;
      endcase
      return result;
   endfunction

endpackage

@@ sv/rqs_channels.sv @@
// Valid/ready channel interfaces for the scheduler's request and response items.
interface rqs_req_if;
   import rqs_pkg::*;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ID_W-1:0]   proc_id;
   logic [PRIO_W-1:0] prio;
   logic [MS_W-1:0]   burst_ms;
   logic              final_burst;

   modport source (output valid, opcode, proc_id, prio, burst_ms, final_burst,
                   input ready);
   modport sink (input valid, opcode, proc_id, prio, burst_ms, final_burst,
                 output ready);
endinterface

interface rqs_rsp_if;
   import rqs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ID_W-1:0]      run_id;
   logic [MS_W-1:0]      run_ms;
   logic [OUTCOME_W-1:0] outcome;
   logic [OCC_W-1:0]     occupancy;

   modport source (output valid, status, run_id, run_ms, outcome, occupancy,
                   input ready);
   modport sink (input valid, status, run_id, run_ms, outcome, occupancy,
                 output ready);
endinterface

@@ sv/ready_queue_scheduler.sv @@
// Ready queue scheduler: process table in one memory with scan and compaction.
//
// Usage: items arrive on req_chan (valid/ready). An enqueue item appends a
// process to the ready table; a dispatch item selects one process by the
// policy register, removes it (round robin writes any time left back to the
// tail) and reports its run time on rsp_chan. Every item produces exactly
// one response item. The user is to write registers policy and quantum
// through csr_we/csr_addr/csr_wdata only while the block is idle; the block
// itself does not enforce this.
// An enqueue, or a dispatch on an empty table, goes from idle to the post
// stage. Any other dispatch makes one pass over the table to find the winner,
// one pass to close the gap behind it, a finish step and a post step. Both
// passes go through the single read port of the table memory, one entry a
// cycle; the block holds one item at a time.
// The response sits in an output register, so the next item is taken while
// a finished response still waits; if the receiver stalls, a second result
// waits in the post stage until the register frees.
// Reset (synchronous, active high) empties the table and sets policy to
// lowest id and the quantum to 10; table contents need no clearing.
module ready_queue_scheduler #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   rqs_req_if.sink                       req_chan,
   rqs_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [rqs_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [rqs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rqs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_POST  = 3'd4;

   entry_type mem [TABLE_DEPTH];

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [POLICY_W-1:0]   policy_ff;
   logic [MS_W-1:0]       quantum_ff;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   entry_type             rd_data_ff;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   entry_type             best_ff, best_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic [MS_W-1:0]       res_ms_ff, res_ms_in;
   logic [OUTCOME_W-1:0]  res_outcome_ff, res_outcome_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [MS_W-1:0]       rsp_ms_ff, rsp_ms_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   entry_type             mem_wdata;
   logic                  req_fire, issue;
   logic [MS_W-1:0]       run_ms, left_ms;
   entry_type             new_entry;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign issue          = (ptr_ff < count_ff);

   assign new_entry.id          = req_chan.proc_id;
   assign new_entry.prio        = req_chan.prio;
   assign new_entry.remaining   = req_chan.burst_ms;
   assign new_entry.final_burst = req_chan.final_burst;

   assign run_ms  = (best_ff.remaining <= quantum_ff) ? best_ff.remaining : quantum_ff;
   assign left_ms = best_ff.remaining - run_ms;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      res_status_in  = res_status_ff;
      res_id_in      = res_id_ff;
      res_ms_in      = res_ms_ff;
      res_outcome_in = res_outcome_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = new_entry;
      mem_re         = 1'b0;
      mem_raddr      = '0;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_ms_in      = rsp_ms_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_occ_in     = rsp_occ_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_id_in      = '0;
               res_ms_in      = '0;
               res_outcome_in = OC_REQUEUED;
               state_in       = S_POST;
               if (req_chan.opcode == OP_ENQUEUE) begin
                  if (count_ff == DEPTH_C) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we        = 1'b1;
                     mem_waddr     = count_ff[AW-1:0];
                     count_in      = count_ff + 1'b1;
                     res_status_in = ST_ENQUEUED;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               mem_re      = 1'b1;
               mem_raddr   = ptr_ff[AW-1:0];
               rd_idx_in   = ptr_ff[AW-1:0];
               rd_valid_in = 1'b1;
               ptr_in      = ptr_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (rd_idx_ff == '0 || is_better(rd_data_ff, best_ff, policy_ff)) begin
                  best_in     = rd_data_ff;
                  best_idx_in = rd_idx_ff;
               end
               // The last entry has come back: start closing the gap behind the winner.
               if (CW'(rd_idx_ff) == count_ff - 1'b1) begin
                  ptr_in   = CW'(best_idx_in) + 1'b1;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // Reads run one entry ahead of the writes, so no entry is read after its rewrite.
            if (issue) begin
               mem_re      = 1'b1;
               mem_raddr   = ptr_ff[AW-1:0];
               rd_idx_in   = ptr_ff[AW-1:0];
               rd_valid_in = 1'b1;
               ptr_in      = ptr_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (!issue && !rd_valid_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_status_in = ST_DISPATCHED;
            res_id_in     = best_ff.id;
            res_outcome_in = best_ff.final_burst ? OC_DONE : OC_IO;
            state_in      = S_POST;
            if (policy_ff == POL_ROUND) begin
               res_ms_in = run_ms;
               if (left_ms != '0) begin
                  // The remainder takes the freed tail slot, so the count stays.
                  mem_we              = 1'b1;
                  mem_waddr           = AW'(count_ff - 1'b1);
                  mem_wdata           = best_ff;
                  mem_wdata.remaining = left_ms;
                  res_outcome_in      = OC_REQUEUED;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end else begin
               res_ms_in = best_ff.remaining;
               count_in  = count_ff - 1'b1;
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_id_in      = res_id_ff;
               rsp_ms_in      = res_ms_ff;
               rsp_outcome_in = res_outcome_ff;
               rsp_occ_in     = OCC_W'(count_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         policy_ff    <= POL_LOWEST_ID;
         quantum_ff   <= QUANTUM_RESET;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_POLICY:  policy_ff  <= csr_wdata[POLICY_W-1:0];
               CSR_QUANTUM: quantum_ff <= csr_wdata[MS_W-1:0];
               default:     policy_ff  <= policy_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      rd_idx_ff      <= rd_idx_in;
      best_idx_ff    <= best_idx_in;
      best_ff        <= best_in;
      res_status_ff  <= res_status_in;
      res_id_ff      <= res_id_in;
      res_ms_ff      <= res_ms_in;
      res_outcome_ff <= res_outcome_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_ms_ff      <= rsp_ms_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.run_id    = rsp_id_ff;
   assign rsp_chan.run_ms    = rsp_ms_ff;
   assign rsp_chan.outcome   = rsp_outcome_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

`include "ready_queue_scheduler_assert.svh"

   `RQS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `RQS_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   `RQS_ASSERT_SAME(a_enqueue_fields, clock, reset,
                    rsp_valid_ff && rsp_status_ff != ST_DISPATCHED,
                    rsp_id_ff == '0 && rsp_ms_ff == '0 && rsp_outcome_ff == OC_REQUEUED)
   `RQS_ASSERT_SAME(a_shift_write_order, clock, reset,
                    state_ff == S_SHIFT && rd_valid_ff,
                    CW'(rd_idx_ff) < count_ff && rd_idx_ff != '0)

endmodule
